@@ hdl/aat_pkg.sv @@
// aat_pkg: shared types and constants of the box transform block
`default_nettype none

package aat_pkg;

  // configuration port geometry
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int ROW_W       = 48;
  localparam int SHIFT_W     = 16;
  localparam int NUM_AXES    = 3;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_e;

  // axis slots in the configuration struct
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // values after reset: x row takes y, y and z rows take z, no translation
  localparam logic [ROW_W-1:0]   ROW_X_RESET = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0]   ROW_Y_RESET = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0]   ROW_Z_RESET = 48'h0000_0000_4000;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 16'h0000;

  // transform held in configuration
  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_W-1:0]   row;
    logic [NUM_AXES-1:0][SHIFT_W-1:0] shift;
  } cfg_t;

  // per-stage load enables of the datapath
  typedef struct packed {
    logic en_mul;
    logic en_sel;
    logic en_sum;
    logic en_out;
  } pipe_ctl_t;

endpackage

`default_nettype wire

@@ hdl/aat_box_if.sv @@
// aat_box_if: input channel carrying one box as min and max corners
`default_nettype none

interface aat_box_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] lo_x;
  logic signed [COORD_WIDTH-1:0] lo_y;
  logic signed [COORD_WIDTH-1:0] lo_z;
  logic signed [COORD_WIDTH-1:0] hi_x;
  logic signed [COORD_WIDTH-1:0] hi_y;
  logic signed [COORD_WIDTH-1:0] hi_z;

  modport source (
    output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
    input  ready
  );

  modport sink (
    input  valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/aat_bound_if.sv @@
// aat_bound_if: output channel carrying one mapped bounding box
`default_nettype none

interface aat_bound_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_lo_x;
  logic signed [COORD_WIDTH-1:0] out_lo_y;
  logic signed [COORD_WIDTH-1:0] out_lo_z;
  logic signed [COORD_WIDTH-1:0] out_hi_x;
  logic signed [COORD_WIDTH-1:0] out_hi_y;
  logic signed [COORD_WIDTH-1:0] out_hi_z;

  modport source (
    output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
    input  ready
  );

  modport sink (
    input  valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/aat_cfg_regs.sv @@
// aat_cfg_regs: configuration register file for the transform
`default_nettype none

module aat_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [aat_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [aat_pkg::CFG_DATA_W-1:0]    cfg_data,
  output aat_pkg::cfg_t                          cfg
);

  aat_pkg::cfg_t regs;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.row[aat_pkg::AXIS_X]   <= aat_pkg::ROW_X_RESET;
      regs.row[aat_pkg::AXIS_Y]   <= aat_pkg::ROW_Y_RESET;
      regs.row[aat_pkg::AXIS_Z]   <= aat_pkg::ROW_Z_RESET;
      regs.shift[aat_pkg::AXIS_X] <= aat_pkg::SHIFT_RESET;
      regs.shift[aat_pkg::AXIS_Y] <= aat_pkg::SHIFT_RESET;
      regs.shift[aat_pkg::AXIS_Z] <= aat_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aat_pkg::REG_ROW_X: begin
          regs.row[aat_pkg::AXIS_X] <= cfg_data[aat_pkg::ROW_W-1:0];
        end
        aat_pkg::REG_ROW_Y: begin
          regs.row[aat_pkg::AXIS_Y] <= cfg_data[aat_pkg::ROW_W-1:0];
        end
        aat_pkg::REG_ROW_Z: begin
          regs.row[aat_pkg::AXIS_Z] <= cfg_data[aat_pkg::ROW_W-1:0];
        end
        aat_pkg::REG_SHIFT_X: begin
          regs.shift[aat_pkg::AXIS_X] <= cfg_data[aat_pkg::SHIFT_W-1:0];
        end
        aat_pkg::REG_SHIFT_Y: begin
          regs.shift[aat_pkg::AXIS_Y] <= cfg_data[aat_pkg::SHIFT_W-1:0];
        end
        aat_pkg::REG_SHIFT_Z: begin
          regs.shift[aat_pkg::AXIS_Z] <= cfg_data[aat_pkg::SHIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

@@ hdl/aat_axis_bound.sv @@
// aat_axis_bound: four-stage datapath giving min and max of one mapped axis
`default_nettype none

module aat_axis_bound #(
  parameter int COORD_WIDTH = 16,
  parameter int COEFF_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire aat_pkg::pipe_ctl_t                 ctl,
  input  wire logic [aat_pkg::ROW_W-1:0]          row,
  input  wire logic [aat_pkg::SHIFT_W-1:0]        shift,
  input  wire logic signed [COORD_WIDTH-1:0]      lo_x,
  input  wire logic signed [COORD_WIDTH-1:0]      lo_y,
  input  wire logic signed [COORD_WIDTH-1:0]      lo_z,
  input  wire logic signed [COORD_WIDTH-1:0]      hi_x,
  input  wire logic signed [COORD_WIDTH-1:0]      hi_y,
  input  wire logic signed [COORD_WIDTH-1:0]      hi_z,
  output logic signed [COORD_WIDTH-1:0]           bound_lo,
  output logic signed [COORD_WIDTH-1:0]           bound_hi
);

  localparam int PW   = COEFF_WIDTH + COORD_WIDTH;      // product width
  localparam int SUMW = PW + 2;                         // sum of three products
  localparam int FRAC = COEFF_WIDTH - 2;                // coefficient fraction bits
  localparam int RW   = COORD_WIDTH + 4;                // sum after dropping fraction
  localparam int SW   = ((RW > aat_pkg::SHIFT_W) ? RW : aat_pkg::SHIFT_W) + 1;
  localparam int PADW = (3 * COEFF_WIDTH > aat_pkg::ROW_W) ?
                        3 * COEFF_WIDTH : aat_pkg::ROW_W;
  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  // coefficient slots, bits above the register read as zero
  logic [PADW-1:0]               row_pad;
  logic signed [COEFF_WIDTH-1:0] cx;
  logic signed [COEFF_WIDTH-1:0] cy;
  logic signed [COEFF_WIDTH-1:0] cz;

  assign row_pad = {{(PADW - aat_pkg::ROW_W){1'b0}}, row};
  assign cx = row_pad[2*COEFF_WIDTH +: COEFF_WIDTH];
  assign cy = row_pad[COEFF_WIDTH +: COEFF_WIDTH];
  assign cz = row_pad[0 +: COEFF_WIDTH];

  // stage 1: each coefficient against both box extents
  logic signed [PW-1:0] p_lo_x, p_hi_x, p_lo_y, p_hi_y, p_lo_z, p_hi_z;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      p_lo_x <= cx * lo_x;
      p_hi_x <= cx * hi_x;
      p_lo_y <= cy * lo_y;
      p_hi_y <= cy * hi_y;
      p_lo_z <= cz * lo_z;
      p_hi_z <= cz * hi_z;
    end
  end

  // stage 2: corners are separable per term, so pick the smaller and larger product
  logic signed [PW-1:0] t_min_x, t_max_x, t_min_y, t_max_y, t_min_z, t_max_z;

  always_ff @(posedge clk) begin
    if (ctl.en_sel) begin
      t_min_x <= (p_lo_x < p_hi_x) ? p_lo_x : p_hi_x;
      t_max_x <= (p_lo_x < p_hi_x) ? p_hi_x : p_lo_x;
      t_min_y <= (p_lo_y < p_hi_y) ? p_lo_y : p_hi_y;
      t_max_y <= (p_lo_y < p_hi_y) ? p_hi_y : p_lo_y;
      t_min_z <= (p_lo_z < p_hi_z) ? p_lo_z : p_hi_z;
      t_max_z <= (p_lo_z < p_hi_z) ? p_hi_z : p_lo_z;
    end
  end

  // stage 3: exact sums of the extreme terms
  logic signed [SUMW-1:0] sum_min;
  logic signed [SUMW-1:0] sum_max;

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      sum_min <= {{2{t_min_x[PW-1]}}, t_min_x} + {{2{t_min_y[PW-1]}}, t_min_y}
               + {{2{t_min_z[PW-1]}}, t_min_z};
      sum_max <= {{2{t_max_x[PW-1]}}, t_max_x} + {{2{t_max_y[PW-1]}}, t_max_y}
               + {{2{t_max_z[PW-1]}}, t_max_z};
    end
  end

  // stage 4: floor shift, translate and saturate (all monotone, so order is kept)
  logic signed [SUMW-1:0] shd_min, shd_max;
  logic signed [SW-1:0]   val_min, val_max;
  logic signed [SW-1:0]   shift_ext;
  logic signed [COORD_WIDTH-1:0] sat_min, sat_max;

  assign shd_min   = sum_min >>> FRAC;
  assign shd_max   = sum_max >>> FRAC;
  assign shift_ext = {{(SW - aat_pkg::SHIFT_W){shift[aat_pkg::SHIFT_W-1]}}, shift};
  assign val_min   = {{(SW - RW){shd_min[RW-1]}}, shd_min[RW-1:0]} + shift_ext;
  assign val_max   = {{(SW - RW){shd_max[RW-1]}}, shd_max[RW-1:0]} + shift_ext;

  always_comb begin
    if (val_min > SAT_HI) begin
      sat_min = SAT_HI[COORD_WIDTH-1:0];
    end else if (val_min < SAT_LO) begin
      sat_min = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      sat_min = val_min[COORD_WIDTH-1:0];
    end
    if (val_max > SAT_HI) begin
      sat_max = SAT_HI[COORD_WIDTH-1:0];
    end else if (val_max < SAT_LO) begin
      sat_max = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      sat_max = val_max[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      bound_lo <= sat_min;
      bound_hi <= sat_max;
    end
  end

endmodule

`default_nettype wire

@@ hdl/aabb_affine_transform_top.sv @@
// aabb_affine_transform_top: maps an axis-aligned box through an affine transform
//
// Takes a box as its min and max corners and returns the componentwise min and
// max of its eight corners mapped through a 3x3 Q2.14 matrix plus translation,
// saturated to the coordinate width. Because each mapped coordinate is a sum of
// independent per-axis terms, the extreme corner is found term by term: every
// coefficient is multiplied against both extents (18 multipliers in all), the
// smaller and larger product of each term are kept, summed, floor-shifted,
// translated and saturated. The datapath is four register stages (products,
// term select, sums, saturated result), so one box is taken every cycle while
// the consumer keeps up, and each box passes through the stages in that order
// before its result is presented. Each stage holds its own valid bit and
// empty stages fill while the output waits on its consumer.
// Configuration is written through cfg_we/cfg_index/cfg_data while no box is
// in flight; indexes 0..2 are the matrix rows, 3..5 the x, y, z translations.
`default_nettype none

module aabb_affine_transform_top #(
  parameter int COORD_WIDTH = 16,
  parameter int COEFF_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [aat_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [aat_pkg::CFG_DATA_W-1:0]   cfg_data,
  aat_box_if.sink                               box_in,
  aat_bound_if.source                           box_out
);

  aat_pkg::cfg_t      cfg;
  aat_pkg::pipe_ctl_t ctl;

  // configuration registers
  aat_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage valid bits and per-stage advance
  logic v_mul, v_sel, v_sum, v_out;
  logic adv_mul, adv_sel, adv_sum, adv_out;

  assign adv_out = !v_out || box_out.ready;
  assign adv_sum = !v_sum || adv_out;
  assign adv_sel = !v_sel || adv_sum;
  assign adv_mul = !v_mul || adv_sel;

  assign ctl.en_out = adv_out;
  assign ctl.en_sum = adv_sum;
  assign ctl.en_sel = adv_sel;
  assign ctl.en_mul = adv_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
      v_sel <= 1'b0;
      v_sum <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (adv_mul) begin
        v_mul <= box_in.valid;
      end
      if (adv_sel) begin
        v_sel <= v_mul;
      end
      if (adv_sum) begin
        v_sum <= v_sel;
      end
      if (adv_out) begin
        v_out <= v_sum;
      end
    end
  end

  assign box_in.ready  = adv_mul;
  assign box_out.valid = v_out;

  // one datapath per output axis
  aat_axis_bound #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_axis_x (
    .clk      (clk),
    .ctl      (ctl),
    .row      (cfg.row[aat_pkg::AXIS_X]),
    .shift    (cfg.shift[aat_pkg::AXIS_X]),
    .lo_x     (box_in.lo_x),
    .lo_y     (box_in.lo_y),
    .lo_z     (box_in.lo_z),
    .hi_x     (box_in.hi_x),
    .hi_y     (box_in.hi_y),
    .hi_z     (box_in.hi_z),
    .bound_lo (box_out.out_lo_x),
    .bound_hi (box_out.out_hi_x)
  );

  aat_axis_bound #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_axis_y (
    .clk      (clk),
    .ctl      (ctl),
    .row      (cfg.row[aat_pkg::AXIS_Y]),
    .shift    (cfg.shift[aat_pkg::AXIS_Y]),
    .lo_x     (box_in.lo_x),
    .lo_y     (box_in.lo_y),
    .lo_z     (box_in.lo_z),
    .hi_x     (box_in.hi_x),
    .hi_y     (box_in.hi_y),
    .hi_z     (box_in.hi_z),
    .bound_lo (box_out.out_lo_y),
    .bound_hi (box_out.out_hi_y)
  );

  aat_axis_bound #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_axis_z (
    .clk      (clk),
    .ctl      (ctl),
    .row      (cfg.row[aat_pkg::AXIS_Z]),
    .shift    (cfg.shift[aat_pkg::AXIS_Z]),
    .lo_x     (box_in.lo_x),
    .lo_y     (box_in.lo_y),
    .lo_z     (box_in.lo_z),
    .hi_x     (box_in.hi_x),
    .hi_y     (box_in.hi_y),
    .hi_z     (box_in.hi_z),
    .bound_lo (box_out.out_lo_z),
    .bound_hi (box_out.out_hi_z)
  );

endmodule

`default_nettype wire

@@ dv/aabb_affine_transform_top_test.sv @@
// aabb_affine_transform_top_test: self-checking bench for the box transform block
module aabb_affine_transform_top_test;
  import aat_pkg::*;

  localparam int COORD_W      = 16;
  localparam int COEFF_W      = 16;
  localparam int FRAC_W       = COEFF_W - 2;
  localparam int CLK_PERIOD   = 4;
  localparam int LATENCY      = 4;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 7;
  localparam int TIMEOUT      = 4_000_000;
  localparam longint COORD_MAX = 32767;
  localparam longint COORD_MIN = -32768;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [COORD_W-1:0] lo [NUM_AXES];
    logic signed [COORD_W-1:0] hi [NUM_AXES];
  } box_t;

  typedef enum int {CS_FULL, CS_NEAR, CS_EDGE} coord_style_e;
  typedef enum int {
    XF_UNIT_RANGE, XF_FULL, XF_MOST_NEG, XF_MOST_POS, XF_AXIS_SWAP, XF_ZERO
  } xform_style_e;

  // expected mapped boxes, in acceptance order, with a private copy of the transform
  class bound_scoreboard;
    logic [ROW_W-1:0]          rows   [NUM_AXES];
    logic signed [SHIFT_W-1:0] shifts [NUM_AXES];
    box_t                      expected_q [$];
    int                        errors;

    function new();
      rows[AXIS_X]   = ROW_X_RESET;
      rows[AXIS_Y]   = ROW_Y_RESET;
      rows[AXIS_Z]   = ROW_Z_RESET;
      shifts[AXIS_X] = SHIFT_RESET;
      shifts[AXIS_Y] = SHIFT_RESET;
      shifts[AXIS_Z] = SHIFT_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
          rows[index - REG_ROW_X] = data[ROW_W-1:0];
        end
        REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: begin
          shifts[index - REG_SHIFT_X] = data[SHIFT_W-1:0];
        end
        default: ;
      endcase
    endfunction

    // one axis of one corner: sum of products, floor shift, translate, saturate
    function longint map_coord(int axis, longint x, longint y, longint z);
      shortint cx, cy, cz;
      longint  acc, v;
      cx  = rows[axis][47:32];
      cy  = rows[axis][31:16];
      cz  = rows[axis][15:0];
      acc = cx * x + cy * y + cz * z;
      v   = (acc >>> FRAC_W) + longint'(shifts[axis]);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v;
    endfunction

    // min and max over all eight corners, seeded from the first corner
    function box_t transform_box(box_t b);
      box_t   r;
      longint x, y, z, v;
      longint vmin [NUM_AXES];
      longint vmax [NUM_AXES];
      for (int c = 0; c < 8; c++) begin
        x = c[0] ? b.hi[AXIS_X] : b.lo[AXIS_X];
        y = c[1] ? b.hi[AXIS_Y] : b.lo[AXIS_Y];
        z = c[2] ? b.hi[AXIS_Z] : b.lo[AXIS_Z];
        for (int a = 0; a < NUM_AXES; a++) begin
          v = map_coord(a, x, y, z);
          if (c == 0 || v < vmin[a]) vmin[a] = v;
          if (c == 0 || v > vmax[a]) vmax[a] = v;
        end
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        r.lo[a] = vmin[a][COORD_W-1:0];
        r.hi[a] = vmax[a][COORD_W-1:0];
      end
      return r;
    endfunction

    function void note_box(box_t b);
      expected_q.push_back(transform_box(b));
    endfunction

    function void check_bound(box_t got);
      box_t  want;
      string tag;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result box, expected none, got lo_x %0d hi_x %0d",
                 $time, got.lo[AXIS_X], got.hi[AXIS_X]);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int a = 0; a < NUM_AXES; a++) begin
        tag = (a == AXIS_X) ? "x" : (a == AXIS_Y) ? "y" : "z";
        if (got.lo[a] !== want.lo[a]) begin
          $display("%0t: out_lo_%s mismatch, expected %0d, got %0d",
                   $time, tag, want.lo[a], got.lo[a]);
          errors++;
        end
        if (got.hi[a] !== want.hi[a]) begin
          $display("%0t: out_hi_%s mismatch, expected %0d, got %0d",
                   $time, tag, want.hi[a], got.hi[a]);
          errors++;
        end
      end
    endfunction

    function int pending_count();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  box_t                   seen_bound;
  bound_scoreboard        sb;

  aat_box_if   #(.COORD_WIDTH(COORD_W)) box_in ();
  aat_bound_if #(.COORD_WIDTH(COORD_W)) box_out ();

  aabb_affine_transform_top #(
    .COORD_WIDTH(COORD_W),
    .COEFF_WIDTH(COEFF_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_in    (box_in),
    .box_out   (box_out)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side backpressure
  always @(negedge clk) begin
    box_out.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && box_out.valid && box_out.ready) begin
      seen_bound.lo[AXIS_X] = box_out.out_lo_x;
      seen_bound.lo[AXIS_Y] = box_out.out_lo_y;
      seen_bound.lo[AXIS_Z] = box_out.out_lo_z;
      seen_bound.hi[AXIS_X] = box_out.out_hi_x;
      seen_bound.hi[AXIS_Y] = box_out.out_hi_y;
      seen_bound.hi[AXIS_Z] = box_out.out_hi_z;
      sb.check_bound(seen_bound);
    end
  end

  // run limit
  initial begin
    #(TIMEOUT);
    $display("simulation failed");
    $finish;
  end

  function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo[AXIS_X] = lx[COORD_W-1:0];
    b.lo[AXIS_Y] = ly[COORD_W-1:0];
    b.lo[AXIS_Z] = lz[COORD_W-1:0];
    b.hi[AXIS_X] = hx[COORD_W-1:0];
    b.hi[AXIS_Y] = hy[COORD_W-1:0];
    b.hi[AXIS_Z] = hz[COORD_W-1:0];
    return b;
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord(coord_style_e style);
    case (style)
      CS_NEAR: return COORD_W'(int'($urandom_range(400)) - 200);
      CS_EDGE: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // mostly full-range boxes, some small ones kept ordered, some at the edges
  function automatic box_t random_box();
    box_t                      b;
    coord_style_e              style;
    int                        pick;
    logic signed [COORD_W-1:0] t;
    pick  = $urandom_range(99);
    style = (pick < 55) ? CS_FULL : (pick < 85) ? CS_NEAR : CS_EDGE;
    for (int a = 0; a < NUM_AXES; a++) begin
      b.lo[a] = random_coord(style);
      b.hi[a] = random_coord(style);
      if (style == CS_NEAR && $urandom_range(3) != 0 && b.lo[a] > b.hi[a]) begin
        t       = b.lo[a];
        b.lo[a] = b.hi[a];
        b.hi[a] = t;
      end
    end
    return b;
  endfunction

  function automatic box_t directed_box(int k);
    case (k)
      0:  return make_box(0, 0, 0, 0, 0, 0);
      1:  return make_box(-32768, -32768, -32768, 32767, 32767, 32767);
      2:  return make_box(32767, 32767, 32767, 32767, 32767, 32767);
      3:  return make_box(-32768, -32768, -32768, -32768, -32768, -32768);
      4:  return make_box(100, 200, 300, -100, -200, -300);
      5:  return make_box(0, 0, 0, 1, 1, 1);
      6:  return make_box(-1, -1, -1, 0, 0, 0);
      7:  return make_box(1, 2, 3, 10, 20, 30);
      8:  return make_box(-32768, 0, 32767, 32767, -1, -32768);
      9:  return make_box('h5555, 'h5555, 'h5555, 'haaaa, 'haaaa, 'haaaa);
      10: return make_box(-1, -1, -1, -1, -1, -1);
      default: return make_box(1234, -4321, 77, 5000, 100, -77);
    endcase
  endfunction

  // offer one box after a random gap, hold it until taken
  task automatic send_box(box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      box_in.valid = 1'b0;
      @(negedge clk);
    end
    box_in.valid = 1'b1;
    box_in.lo_x  = b.lo[AXIS_X];
    box_in.lo_y  = b.lo[AXIS_Y];
    box_in.lo_z  = b.lo[AXIS_Z];
    box_in.hi_x  = b.hi[AXIS_X];
    box_in.hi_y  = b.hi[AXIS_Y];
    box_in.hi_z  = b.hi[AXIS_Z];
    do @(posedge clk); while (!box_in.ready);
    sb.note_box(b);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(index, data);
  endtask

  // wait until every expected box is back and the pipeline is empty
  task automatic drain();
    box_in.valid = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic load_transform(xform_style_e style);
    logic [15:0] c [NUM_AXES][NUM_AXES];
    logic [15:0] s [NUM_AXES];
    int          keep;
    for (int a = 0; a < NUM_AXES; a++) begin
      keep = $urandom_range(2);
      for (int k = 0; k < NUM_AXES; k++) begin
        case (style)
          XF_UNIT_RANGE: c[a][k] = 16'(int'($urandom_range(32768)) - 16384);
          XF_MOST_NEG:   c[a][k] = 16'h8000;
          XF_MOST_POS:   c[a][k] = 16'h7fff;
          XF_AXIS_SWAP:  c[a][k] = (k != keep) ? 16'h0000 :
                                   ($urandom_range(1) ? 16'h4000 : 16'hc000);
          XF_ZERO:       c[a][k] = 16'h0000;
          default:       c[a][k] = 16'($urandom);
        endcase
      end
      case (style)
        XF_UNIT_RANGE: s[a] = 16'(int'($urandom_range(2000)) - 1000);
        XF_MOST_NEG:   s[a] = 16'h8000;
        XF_MOST_POS:   s[a] = 16'h7fff;
        XF_AXIS_SWAP:  s[a] = 16'(int'($urandom_range(200)) - 100);
        default:       s[a] = 16'($urandom);
      endcase
    end
    // row slots: x term in the top slot, z term in the bottom one
    for (int a = 0; a < NUM_AXES; a++) begin
      write_reg(CFG_INDEX_W'(REG_ROW_X + a), {c[a][0], c[a][1], c[a][2]});
    end
    // translations carry junk above bit 15, which must be dropped
    for (int a = 0; a < NUM_AXES; a++) begin
      write_reg(CFG_INDEX_W'(REG_SHIFT_X + a), {32'($urandom), s[a]});
    end
    if ($urandom_range(1)) begin
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                {16'($urandom), 32'($urandom)});
    end
  endtask

  // main sequence
  initial begin
    sb            = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_ROW_X;
    cfg_data      = '0;
    box_in.valid  = 1'b0;
    box_in.lo_x   = '0;
    box_in.lo_y   = '0;
    box_in.lo_z   = '0;
    box_in.hi_x   = '0;
    box_in.hi_y   = '0;
    box_in.hi_z   = '0;
    box_out.ready = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 83;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed boxes under the reset transform
    for (int k = 0; k < 12; k++) send_box(directed_box(k));
    drain();

    // same boxes under a saturating transform, plus writes to unused indexes
    write_reg(REG_ROW_X, 48'h7fff_7fff_7fff);
    write_reg(REG_ROW_Y, 48'h8000_8000_8000);
    write_reg(REG_ROW_Z, 48'h7fff_8000_0001);
    write_reg(REG_SHIFT_X, 48'h0000_0000_7fff);
    write_reg(REG_SHIFT_Y, 48'hffff_ffff_8000);
    write_reg(REG_SHIFT_Z, 48'h0000_0000_ffff);
    write_reg(REG_SPARE_LO, 48'h1234_5678_9abc);
    write_reg(REG_SPARE_HI, 48'hffff_ffff_ffff);
    for (int k = 0; k < 12; k++) send_box(directed_box(k));
    drain();

    // random boxes, a new transform per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 83;
      end else if (p < 5) begin
        send_idle_pct = 83;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: load_transform(XF_UNIT_RANGE);
        1: load_transform(XF_FULL);
        2: load_transform(XF_MOST_NEG);
        3: load_transform(XF_MOST_POS);
        4: load_transform(XF_AXIS_SWAP);
        5: load_transform(XF_ZERO);
        default: load_transform(XF_FULL);
      endcase
      repeat (PHASE_ITEMS) send_box(random_box());
      drain();
    end

    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/aat_pkg.sv
hdl/aat_box_if.sv
hdl/aat_bound_if.sv
hdl/aat_cfg_regs.sv
hdl/aat_axis_bound.sv
hdl/aabb_affine_transform_top.sv
dv/aabb_affine_transform_top_test.sv
